>>> hdl/qmp_pkg.sv
// Shared types, register codes, reset values and rounding helper for the prediction unit.
package qmp_pkg;

  localparam int WordW = 32;
  localparam int ElemW = 33;
  localparam int RndW  = 36;
  localparam int NumRegs = 6;
  localparam int RegIdxW = 3;

  typedef logic signed [WordW-1:0] word_t;
  typedef word_t [2:0]             vec_t;
  typedef logic signed [ElemW-1:0] elem_t;
  typedef elem_t [8:0]             mat_t;
  typedef logic [RegIdxW-1:0]      reg_idx_t;

  // Matrix beat handed from the matrix pipe to the projection pipe
  typedef struct packed {
    mat_t m;
    vec_t acc_bias;
    vec_t mag_bias;
  } mat_beat_t;

  // Configuration register indexes
  localparam reg_idx_t REG_REF_ACC_X = 3'd0;
  localparam reg_idx_t REG_REF_ACC_Y = 3'd1;
  localparam reg_idx_t REG_REF_ACC_Z = 3'd2;
  localparam reg_idx_t REG_REF_MAG_X = 3'd3;
  localparam reg_idx_t REG_REF_MAG_Y = 3'd4;
  localparam reg_idx_t REG_REF_MAG_Z = 3'd5;

  // Reset values, Q16.16
  localparam word_t REF_ACC_X_RST = 32'sd0;
  localparam word_t REF_ACC_Y_RST = 32'sd0;
  localparam word_t REF_ACC_Z_RST = -32'sd642691;
  localparam word_t REF_MAG_X_RST = 32'sd870318;
  localparam word_t REF_MAG_Y_RST = -32'sd209715;
  localparam word_t REF_MAG_Z_RST = 32'sd1389363;

  localparam word_t WORD_MAX = 32'sh7fffffff;
  localparam word_t WORD_MIN = 32'sh80000000;

  // Round half up at bit 30: floor((v + 2^29) / 2^30)
  function automatic logic signed [RndW-1:0] round_q30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd536870912;
    return RndW'(t >>> 30);
  endfunction

endpackage

>>> hdl/qmp_matrix.sv
// Three-stage pipe: quaternion products, rounding, rotation matrix sums with clamp.
module qmp_matrix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qmp_pkg::word_t    quat_a_i,
  input  qmp_pkg::word_t    quat_b_i,
  input  qmp_pkg::word_t    quat_c_i,
  input  qmp_pkg::word_t    quat_s_i,
  input  qmp_pkg::vec_t     acc_bias_i,
  input  qmp_pkg::vec_t     mag_bias_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qmp_pkg::mat_beat_t out_beat_o
);
  import qmp_pkg::*;

  localparam int NumProd = 10;
  localparam int P_AA = 0;
  localparam int P_BB = 1;
  localparam int P_CC = 2;
  localparam int P_SS = 3;
  localparam int P_AB = 4;
  localparam int P_CS = 5;
  localparam int P_AC = 6;
  localparam int P_BS = 7;
  localparam int P_BC = 8;
  localparam int P_SA = 9;
  localparam int ProdW = 64;
  localparam int RW    = 34;
  localparam int SumW  = 37;
  localparam logic signed [SumW-1:0] ElemMax = 37'sd4294967295;

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  logic signed [ProdW-1:0] prod_d [NumProd];
  logic signed [ProdW-1:0] prod_q [NumProd];
  logic signed [RW-1:0]    rnd_d  [NumProd];
  logic signed [RW-1:0]    rnd_q  [NumProd];
  logic signed [SumW-1:0]  ext    [NumProd];
  logic signed [SumW-1:0]  sum_d  [9];
  mat_t mat_d, mat_q;
  vec_t acc_b1_q, mag_b1_q, acc_b2_q, mag_b2_q, acc_b3_q, mag_b3_q;

  // Ready chain: a stage takes a beat when empty or when it drains
  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Stage 1: the ten pairwise products, Q4.60
  always_comb begin
    prod_d[P_AA] = quat_a_i * quat_a_i;
    prod_d[P_BB] = quat_b_i * quat_b_i;
    prod_d[P_CC] = quat_c_i * quat_c_i;
    prod_d[P_SS] = quat_s_i * quat_s_i;
    prod_d[P_AB] = quat_a_i * quat_b_i;
    prod_d[P_CS] = quat_c_i * quat_s_i;
    prod_d[P_AC] = quat_a_i * quat_c_i;
    prod_d[P_BS] = quat_b_i * quat_s_i;
    prod_d[P_BC] = quat_b_i * quat_c_i;
    prod_d[P_SA] = quat_s_i * quat_a_i;
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      prod_q   <= prod_d;
      acc_b1_q <= acc_bias_i;
      mag_b1_q <= mag_bias_i;
    end
  end

  // Stage 2: round each product to Q.30
  always_comb begin
    for (int k = 0; k < NumProd; k++) begin
      rnd_d[k] = RW'(round_q30(66'(prod_q[k])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      rnd_q    <= rnd_d;
      acc_b2_q <= acc_b1_q;
      mag_b2_q <= mag_b1_q;
    end
  end

  // Stage 3: matrix elements, row-major, clamped to +/-(2^32-1)
  always_comb begin
    for (int k = 0; k < NumProd; k++) begin
      ext[k] = SumW'(rnd_q[k]);
    end
    sum_d[0] = ext[P_AA] - ext[P_BB] - ext[P_CC] + ext[P_SS];
    sum_d[1] = (ext[P_AB] + ext[P_CS]) <<< 1;
    sum_d[2] = (ext[P_AC] - ext[P_BS]) <<< 1;
    sum_d[3] = (ext[P_AB] - ext[P_CS]) <<< 1;
    sum_d[4] = -ext[P_AA] + ext[P_BB] - ext[P_CC] + ext[P_SS];
    sum_d[5] = (ext[P_BC] + ext[P_SA]) <<< 1;
    sum_d[6] = (ext[P_AC] + ext[P_BS]) <<< 1;
    sum_d[7] = (ext[P_BC] - ext[P_SA]) <<< 1;
    sum_d[8] = -ext[P_AA] - ext[P_BB] + ext[P_CC] + ext[P_SS];
    for (int e = 0; e < 9; e++) begin
      if (sum_d[e] > ElemMax) begin
        mat_d[e] = ElemW'(ElemMax);
      end else if (sum_d[e] < -ElemMax) begin
        mat_d[e] = ElemW'(-ElemMax);
      end else begin
        mat_d[e] = ElemW'(sum_d[e]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      mat_q    <= mat_d;
      acc_b3_q <= acc_b2_q;
      mag_b3_q <= mag_b2_q;
    end
  end

  assign out_valid_o         = s3_valid_q;
  assign out_beat_o.m        = mat_q;
  assign out_beat_o.acc_bias = acc_b3_q;
  assign out_beat_o.mag_bias = mag_b3_q;

endmodule

>>> hdl/qmp_project.sv
// Three-stage pipe: matrix times both reference vectors, rounding, bias add with saturation.
module qmp_project (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qmp_pkg::mat_beat_t in_beat_i,
  input  qmp_pkg::vec_t      ref_acc_i,
  input  qmp_pkg::vec_t      ref_mag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qmp_pkg::vec_t      pred_acc_o,
  output qmp_pkg::vec_t      pred_mag_o
);
  import qmp_pkg::*;

  localparam int ProdW = 65;
  localparam int SumW  = 38;
  localparam logic signed [SumW-1:0] SatMax = SumW'(WORD_MAX);
  localparam logic signed [SumW-1:0] SatMin = SumW'(WORD_MIN);

  logic s4_valid_q, s5_valid_q, s6_valid_q;
  logic s4_ready, s5_ready, s6_ready;

  vec_t ref_v [2];
  vec_t bias4_q [2];
  vec_t bias5_q [2];
  logic signed [ProdW-1:0] prod_d [2][3][3];
  logic signed [ProdW-1:0] prod_q [2][3][3];
  logic signed [RndW-1:0]  rnd_d  [2][3][3];
  logic signed [RndW-1:0]  rnd_q  [2][3][3];
  logic signed [SumW-1:0]  sum    [2][3];
  vec_t pred_d [2];
  vec_t pred_q [2];

  assign s6_ready   = !s6_valid_q || out_ready_i;
  assign s5_ready   = !s5_valid_q || s6_ready;
  assign s4_ready   = !s4_valid_q || s5_ready;
  assign in_ready_o = s4_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      if (s4_ready) s4_valid_q <= in_valid_i;
      if (s5_ready) s5_valid_q <= s4_valid_q;
      if (s6_ready) s6_valid_q <= s5_valid_q;
    end
  end

  // Stage 4: eighteen element-by-reference products, Q.46
  assign ref_v[0] = ref_acc_i;
  assign ref_v[1] = ref_mag_i;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_d[k][i][j] = $signed(in_beat_i.m[3*i+j]) * $signed(ref_v[k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && in_valid_i) begin
      prod_q     <= prod_d;
      bias4_q[0] <= in_beat_i.acc_bias;
      bias4_q[1] <= in_beat_i.mag_bias;
    end
  end

  // Stage 5: round every term to Q16.16
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rnd_d[k][i][j] = round_q30(66'(prod_q[k][i][j]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_ready && s4_valid_q) begin
      rnd_q   <= rnd_d;
      bias5_q <= bias4_q;
    end
  end

  // Stage 6: exact row sum plus bias, saturated to 32 bits
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        sum[k][i] = SumW'(bias5_q[k][i]) + SumW'(rnd_q[k][i][0])
                  + SumW'(rnd_q[k][i][1]) + SumW'(rnd_q[k][i][2]);
        if (sum[k][i] > SatMax) begin
          pred_d[k][i] = WORD_MAX;
        end else if (sum[k][i] < SatMin) begin
          pred_d[k][i] = WORD_MIN;
        end else begin
          pred_d[k][i] = WordW'(sum[k][i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s6_ready && s5_valid_q) begin
      pred_q <= pred_d;
    end
  end

  assign out_valid_o = s6_valid_q;
  assign pred_acc_o  = pred_q[0];
  assign pred_mag_o  = pred_q[1];

endmodule

>>> hdl/quaternion_measurement_prediction_unit.sv
// Top level: reference registers, matrix pipe and projection pipe of the prediction unit.
//
// Predicts accelerometer and magnetometer readings from an attitude quaternion:
// pred = R(q) * ref + bias for the gravity and the magnetic references.
// Input channel: in_valid_i / in_ready_o, one beat holds the quaternion (Q2.30)
// and both bias vectors (Q16.16). Output channel: out_valid_o / out_ready_i,
// one beat holds the six saturated Q16.16 predictions.
// Reference vectors are written through cfg_we_i / cfg_index_i / cfg_wdata_i,
// one register per cycle; indexes six and seven are ignored. Write only while
// the pipe is empty.
// Six register stages: products, rounding, matrix sums, vector products,
// rounding, bias sum and saturation. Throughput: one beat per cycle while the
// receiver keeps taking output beats.
// Reset empties the pipe and loads the default references (standard gravity,
// a nominal field vector). When the receiver stalls, each stage holds its beat
// and empty stages keep filling; in_ready_o drops once all six stages are full.
module quaternion_measurement_prediction_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  qmp_pkg::reg_idx_t       cfg_index_i,
  input  qmp_pkg::word_t          cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  qmp_pkg::word_t          quat_a_i,
  input  qmp_pkg::word_t          quat_b_i,
  input  qmp_pkg::word_t          quat_c_i,
  input  qmp_pkg::word_t          quat_s_i,
  input  qmp_pkg::word_t          acc_bias_x_i,
  input  qmp_pkg::word_t          acc_bias_y_i,
  input  qmp_pkg::word_t          acc_bias_z_i,
  input  qmp_pkg::word_t          mag_bias_x_i,
  input  qmp_pkg::word_t          mag_bias_y_i,
  input  qmp_pkg::word_t          mag_bias_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output qmp_pkg::word_t          pred_acc_x_o,
  output qmp_pkg::word_t          pred_acc_y_o,
  output qmp_pkg::word_t          pred_acc_z_o,
  output qmp_pkg::word_t          pred_mag_x_o,
  output qmp_pkg::word_t          pred_mag_y_o,
  output qmp_pkg::word_t          pred_mag_z_o
);
  import qmp_pkg::*;

  vec_t      ref_acc_q, ref_mag_q;
  vec_t      acc_bias, mag_bias, pred_acc, pred_mag;
  logic      mat_valid, mat_ready;
  mat_beat_t mat_beat;

  // Reference vector registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_acc_q <= {REF_ACC_Z_RST, REF_ACC_Y_RST, REF_ACC_X_RST};
      ref_mag_q <= {REF_MAG_Z_RST, REF_MAG_Y_RST, REF_MAG_X_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_REF_ACC_X: ref_acc_q[0] <= cfg_wdata_i;
        REG_REF_ACC_Y: ref_acc_q[1] <= cfg_wdata_i;
        REG_REF_ACC_Z: ref_acc_q[2] <= cfg_wdata_i;
        REG_REF_MAG_X: ref_mag_q[0] <= cfg_wdata_i;
        REG_REF_MAG_Y: ref_mag_q[1] <= cfg_wdata_i;
        REG_REF_MAG_Z: ref_mag_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign acc_bias = {acc_bias_z_i, acc_bias_y_i, acc_bias_x_i};
  assign mag_bias = {mag_bias_z_i, mag_bias_y_i, mag_bias_x_i};

  // Rotation matrix pipe
  qmp_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .quat_a_i    (quat_a_i),
    .quat_b_i    (quat_b_i),
    .quat_c_i    (quat_c_i),
    .quat_s_i    (quat_s_i),
    .acc_bias_i  (acc_bias),
    .mag_bias_i  (mag_bias),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .out_beat_o  (mat_beat)
  );

  // Projection of both references
  qmp_project u_project (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mat_valid),
    .in_ready_o  (mat_ready),
    .in_beat_i   (mat_beat),
    .ref_acc_i   (ref_acc_q),
    .ref_mag_i   (ref_mag_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pred_acc_o  (pred_acc),
    .pred_mag_o  (pred_mag)
  );

  assign pred_acc_x_o = pred_acc[0];
  assign pred_acc_y_o = pred_acc[1];
  assign pred_acc_z_o = pred_acc[2];
  assign pred_mag_x_o = pred_mag[0];
  assign pred_mag_y_o = pred_mag[1];
  assign pred_mag_z_o = pred_mag[2];

  // Internal handoff: a stalled matrix beat stays put
  a_mat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mat_valid && !mat_ready |=> mat_valid && $stable(mat_beat))
    else $error("matrix beat dropped or changed while stalled");

  // An empty output stage means the whole pipe has room
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  // A free projection pipe always takes the matrix beat
  a_mat_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> mat_ready)
    else $error("projection pipe stalled with an empty output stage");

endmodule

>>> test/qmp_prediction_checker.sv
// Predictor and scoreboard for the prediction unit, fed from the config port and both channels.
module qmp_prediction_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  qmp_pkg::reg_idx_t cfg_index_i,
  input  qmp_pkg::word_t    cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  qmp_pkg::word_t    quat_a_i,
  input  qmp_pkg::word_t    quat_b_i,
  input  qmp_pkg::word_t    quat_c_i,
  input  qmp_pkg::word_t    quat_s_i,
  input  qmp_pkg::vec_t     acc_bias_i,
  input  qmp_pkg::vec_t     mag_bias_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  qmp_pkg::vec_t     pred_acc_i,
  input  qmp_pkg::vec_t     pred_mag_i,
  output int                mismatches_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qmp_pkg::*;

  localparam longint ElemLimit = 64'sd4294967295;
  localparam int     MaxReports = 10;

  // acc x,y,z in words 0..2, mag x,y,z in words 3..5
  typedef word_t [5:0] reading_set_t;

  vec_t         ref_acc;
  vec_t         ref_mag;
  reading_set_t predictions_q [$];

  // Round half up from Q.60/Q.46 down by 30 bits (arithmetic shift is a floor)
  function automatic longint round_half_up_30(input longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint clamp_elem(input longint v);
    if (v > ElemLimit) return ElemLimit;
    if (v < -ElemLimit) return -ElemLimit;
    return v;
  endfunction

  function automatic word_t saturate_word(input longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  // One sensor: rotated reference plus bias, per axis
  function automatic vec_t rotate_reference(input longint m [9], input vec_t refv,
                                            input vec_t bias);
    longint total;
    vec_t   v;
    for (int i = 0; i < 3; i++) begin
      total = longint'($signed(bias[i]));
      for (int j = 0; j < 3; j++)
        total += round_half_up_30(m[3*i+j] * longint'($signed(refv[j])));
      v[i] = saturate_word(total);
    end
    return v;
  endfunction

  function automatic reading_set_t predict_readings(input word_t a, b, c, s,
                                                    input vec_t acc_b, mag_b,
                                                    input vec_t r_acc, r_mag);
    longint la, lb, lc, ls;
    longint aa, bb, cc, ss, ab, cs, ac, bs, bc, sa;
    longint m [9];
    la = longint'($signed(a));
    lb = longint'($signed(b));
    lc = longint'($signed(c));
    ls = longint'($signed(s));
    aa = round_half_up_30(la * la);
    bb = round_half_up_30(lb * lb);
    cc = round_half_up_30(lc * lc);
    ss = round_half_up_30(ls * ls);
    ab = round_half_up_30(la * lb);
    cs = round_half_up_30(lc * ls);
    ac = round_half_up_30(la * lc);
    bs = round_half_up_30(lb * ls);
    bc = round_half_up_30(lb * lc);
    sa = round_half_up_30(ls * la);
    // Rotation matrix, row-major, no normalization
    m[0] = aa - bb - cc + ss;
    m[1] = 2 * (ab + cs);
    m[2] = 2 * (ac - bs);
    m[3] = 2 * (ab - cs);
    m[4] = -aa + bb - cc + ss;
    m[5] = 2 * (bc + sa);
    m[6] = 2 * (ac + bs);
    m[7] = 2 * (bc - sa);
    m[8] = -aa - bb + cc + ss;
    for (int i = 0; i < 9; i++) m[i] = clamp_elem(m[i]);
    return {rotate_reference(m, r_mag, mag_b), rotate_reference(m, r_acc, acc_b)};
  endfunction

  // Track the references, queue predictions, score output beats
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    reading_set_t seen;
    reading_set_t want;
    if (!rst_ni) begin
      ref_acc <= {REF_ACC_Z_RST, REF_ACC_Y_RST, REF_ACC_X_RST};
      ref_mag <= {REF_MAG_Z_RST, REF_MAG_Y_RST, REF_MAG_X_RST};
      predictions_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_REF_ACC_X: ref_acc[0] <= cfg_wdata_i;
          REG_REF_ACC_Y: ref_acc[1] <= cfg_wdata_i;
          REG_REF_ACC_Z: ref_acc[2] <= cfg_wdata_i;
          REG_REF_MAG_X: ref_mag[0] <= cfg_wdata_i;
          REG_REF_MAG_Y: ref_mag[1] <= cfg_wdata_i;
          REG_REF_MAG_Z: ref_mag[2] <= cfg_wdata_i;
          default: ; // spare indexes are dropped
        endcase
      end

      if (in_valid_i && in_ready_i)
        predictions_q.push_back(predict_readings(quat_a_i, quat_b_i, quat_c_i, quat_s_i,
                                                 acc_bias_i, mag_bias_i, ref_acc, ref_mag));

      if (out_valid_i && out_ready_i) begin
        seen = {pred_mag_i, pred_acc_i};
        if (predictions_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MaxReports)
            $display("[%0t] ERROR: output beat with no prediction pending: %h", $realtime, seen);
        end else begin
          want = predictions_q.pop_front();
          checked_o++;
          for (int i = 0; i < 6; i++) begin
            if (seen[i] !== want[i]) begin
              mismatches_o++;
              if (mismatches_o <= MaxReports)
                $display("[%0t] ERROR: pred_%s_%s expected %0d (%h) got %0d (%h)",
                         $realtime, (i < 3) ? "acc" : "mag",
                         (i % 3 == 0) ? "x" : ((i % 3 == 1) ? "y" : "z"),
                         want[i], want[i], seen[i], seen[i]);
            end
          end
        end
      end
      pending_o = predictions_q.size();
    end
  end

endmodule

>>> test/quaternion_measurement_prediction_unit_tb.sv
// Testbench top: clock, reset, reference setup, stimulus, flow control and verdict.
module quaternion_measurement_prediction_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qmp_pkg::*;

  // Quaternion and data constants
  localparam word_t Q30_ONE       = 32'sh4000_0000;
  localparam word_t Q30_NEG_ONE   = -32'sh4000_0000;
  localparam word_t Q30_COS45     = 32'sd759250125;
  localparam word_t TIE_HI        = 32'sd32768;
  localparam word_t TIE_LO        = 32'sd16384;
  localparam word_t TIE_HI_NEG    = -32'sd32768;
  localparam word_t PATTERN_5     = 32'h5555_5555;
  localparam word_t PATTERN_A     = 32'hAAAA_AAAA;
  localparam word_t ZW            = '0;
  localparam vec_t  ZV            = '0;
  localparam vec_t  VMAX          = {3{WORD_MAX}};
  localparam vec_t  VMIN          = {3{WORD_MIN}};
  localparam vec_t  VALT          = {WORD_MAX, WORD_MIN, WORD_MAX};
  localparam vec_t  VALT_N        = {WORD_MIN, WORD_MAX, WORD_MIN};
  localparam word_t MINUS_ONE_LSB = -32'sd1;

  // Indexes past the last reference register; writes there are dropped
  localparam reg_idx_t REG_SPARE_LO = 3'd6;
  localparam reg_idx_t REG_SPARE_HI = 3'd7;

  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t s;
    vec_t  acc_bias;
    vec_t  mag_bias;
  } quat_beat_t;

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     cfg_we      = 1'b0;
  reg_idx_t cfg_index   = REG_REF_ACC_X;
  word_t    cfg_wdata   = '0;
  logic     in_valid    = 1'b0;
  word_t    quat_a      = '0;
  word_t    quat_b      = '0;
  word_t    quat_c      = '0;
  word_t    quat_s      = '0;
  vec_t     acc_bias    = '0;
  vec_t     mag_bias    = '0;
  logic     out_ready   = 1'b0;
  wire      in_ready;
  wire      out_valid;
  wire vec_t pred_acc;
  wire vec_t pred_mag;

  int mismatches;
  int pending;
  int checked;
  int beats_sent    = 0;
  int settings_used = 1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left     = 0;

  quaternion_measurement_prediction_unit u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .quat_a_i     (quat_a),
    .quat_b_i     (quat_b),
    .quat_c_i     (quat_c),
    .quat_s_i     (quat_s),
    .acc_bias_x_i (acc_bias[0]),
    .acc_bias_y_i (acc_bias[1]),
    .acc_bias_z_i (acc_bias[2]),
    .mag_bias_x_i (mag_bias[0]),
    .mag_bias_y_i (mag_bias[1]),
    .mag_bias_z_i (mag_bias[2]),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pred_acc_x_o (pred_acc[0]),
    .pred_acc_y_o (pred_acc[1]),
    .pred_acc_z_o (pred_acc[2]),
    .pred_mag_x_o (pred_mag[0]),
    .pred_mag_y_o (pred_mag[1]),
    .pred_mag_z_o (pred_mag[2])
  );

  qmp_prediction_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .quat_a_i     (quat_a),
    .quat_b_i     (quat_b),
    .quat_c_i     (quat_c),
    .quat_s_i     (quat_s),
    .acc_bias_i   (acc_bias),
    .mag_bias_i   (mag_bias),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .pred_acc_i   (pred_acc),
    .pred_mag_i   (pred_mag),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("quaternion_measurement_prediction_unit verification failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one beat after a random idle gap, return at the accepting edge
  task automatic send_beat(input quat_beat_t beat);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_a   <= beat.a;
    quat_b   <= beat.b;
    quat_c   <= beat.c;
    quat_s   <= beat.s;
    acc_bias <= beat.acc_bias;
    mag_bias <= beat.mag_bias;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Stop offering and wait for every prediction to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input word_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // All six references by name, plus writes to the spare indexes
  task automatic load_refs(input vec_t r_acc, input vec_t r_mag);
    write_reg(REG_REF_ACC_X, r_acc[0]);
    write_reg(REG_REF_ACC_Y, r_acc[1]);
    write_reg(REG_REF_ACC_Z, r_acc[2]);
    write_reg(REG_REF_MAG_X, r_mag[0]);
    write_reg(REG_REF_MAG_Y, r_mag[1]);
    write_reg(REG_REF_MAG_Z, r_mag[2]);
    write_reg(REG_SPARE_LO, word_t'($urandom));
    write_reg(REG_SPARE_HI, word_t'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic vec_t random_ref(input bit full_range);
    vec_t v;
    for (int i = 0; i < 3; i++)
      v[i] = full_range ? word_t'($urandom)
                        : word_t'(int'($urandom_range(1 << 23)) - (1 << 22));
    return v;
  endfunction

  function automatic word_t random_quat_part();
    case ($urandom_range(9))
      0: return word_t'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return ZW;
          1: return Q30_ONE;
          2: return Q30_NEG_ONE;
          3: return WORD_MAX;
          default: return WORD_MIN;
        endcase
      end
      default: return word_t'($urandom_range(32'h8000_0000)) - Q30_ONE;
    endcase
  endfunction

  function automatic word_t random_bias();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return word_t'(int'($urandom_range(1 << 21)) - (1 << 20));
      5, 6, 7: return word_t'($urandom);
      8: return ($urandom_range(1) != 0) ? WORD_MAX : WORD_MIN;
      default: return ZW;
    endcase
  endfunction

  // Unit quaternions as a filter would send in two fifths of beats, the rest raw part values
  function automatic quat_beat_t random_beat();
    quat_beat_t beat;
    real w [4];
    real norm;
    if ($urandom_range(99) < 40) begin
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
        w[k] = real'(int'($urandom_range(2000000)) - 1000000) / 1.0e6;
        norm += w[k] * w[k];
      end
      norm = (norm < 1.0e-6) ? 1.0 : $sqrt(norm);
      beat.a = word_t'($rtoi(w[0] / norm * 1073741824.0));
      beat.b = word_t'($rtoi(w[1] / norm * 1073741824.0));
      beat.c = word_t'($rtoi(w[2] / norm * 1073741824.0));
      beat.s = word_t'($rtoi(w[3] / norm * 1073741824.0));
    end else begin
      beat.a = random_quat_part();
      beat.b = random_quat_part();
      beat.c = random_quat_part();
      beat.s = random_quat_part();
    end
    for (int i = 0; i < 3; i++) begin
      beat.acc_bias[i] = random_bias();
      beat.mag_bias[i] = random_bias();
    end
    return beat;
  endfunction

  // Corner beats: identity, zero and axis rotations, range edges, rounding ties
  task automatic send_directed();
    send_beat({ZW, ZW, ZW, Q30_ONE, ZV, ZV});
    send_beat({ZW, ZW, ZW, ZW, ZV, ZV});
    send_beat({ZW, ZW, ZW, ZW, VMAX, VMIN});
    send_beat({ZW, ZW, ZW, Q30_ONE, VMAX, VMAX});
    send_beat({ZW, ZW, ZW, Q30_ONE, VMIN, VMIN});
    send_beat({Q30_ONE, ZW, ZW, ZW, ZV, ZV});
    send_beat({ZW, Q30_ONE, ZW, ZW, ZV, ZV});
    send_beat({ZW, ZW, Q30_ONE, ZW, ZV, ZV});
    // unnormalized
    send_beat({Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE, ZV, ZV});
    send_beat({Q30_NEG_ONE, Q30_NEG_ONE, Q30_NEG_ONE, Q30_NEG_ONE, VALT, VALT_N});
    // parts at the edges of Q2.30, matrix clamp engaged
    send_beat({WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, ZV, ZV});
    send_beat({WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, VMAX, VMIN});
    send_beat({WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, VMIN, VMAX});
    // quarter turns
    send_beat({ZW, ZW, Q30_COS45, Q30_COS45, ZV, ZV});
    send_beat({Q30_COS45, ZW, ZW, Q30_COS45, ZV, ZV});
    send_beat({Q30_NEG_ONE, ZW, ZW, Q30_ONE, VALT, VALT_N});
    // products landing exactly on the rounding half point
    send_beat({TIE_HI, TIE_LO, TIE_HI_NEG, TIE_LO, {3{MINUS_ONE_LSB}}, ZV});
    send_beat({TIE_HI_NEG, TIE_LO, TIE_HI, TIE_HI_NEG, ZV, {3{MINUS_ONE_LSB}}});
    send_beat({PATTERN_5, PATTERN_A, PATTERN_5, PATTERN_A, {PATTERN_5, PATTERN_A, PATTERN_5},
               {PATTERN_A, PATTERN_5, PATTERN_A}});
  endtask

  task automatic run_phase(input bit load, input vec_t r_acc, input vec_t r_mag,
                           input int send_pct, input int recv_pct,
                           input bit with_directed, input int n_random);
    drain();
    if (load) load_refs(r_acc, r_mag);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (with_directed) send_directed();
    repeat (n_random) send_beat(random_beat());
  endtask

  // Main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset references, free-running flow
    run_phase(1'b0, ZV, ZV, 0, 0, 1'b1, 150);
    // extreme references with sender idles, then with receiver stalls; then small random ones
    run_phase(1'b1, VMAX, VMAX, 72, 0, 1'b1, 200);
    run_phase(1'b1, VMIN, VMIN, 0, 72, 1'b1, 200);
    run_phase(1'b1, random_ref(1'b0), random_ref(1'b0), 30, 30, 1'b0, 250);

    // long output hold while the sender keeps pushing: pipe fills, input stalls
    drain();
    load_refs(random_ref(1'b1), random_ref(1'b1));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    repeat (40) send_beat(random_beat());
    repeat (200) send_beat(random_beat());

    run_phase(1'b1, ZV, ZV, 72, 72, 1'b0, 150);
    run_phase(1'b1, {ZW, WORD_MIN, WORD_MAX}, {MINUS_ONE_LSB, WORD_MAX, WORD_MIN},
              72, 0, 1'b1, 200);
    run_phase(1'b1, random_ref(1'b1), random_ref(1'b1), 0, 72, 1'b0, 200);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d quaternion beats over %0d reference settings,", beats_sent,
             settings_used);
    $display("four idle/stall mixes and one long output hold; %0d predictions compared.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("quaternion_measurement_prediction_unit verification clean");
    end else begin
      $display("quaternion_measurement_prediction_unit verification failed");
    end
    $finish;
  end

endmodule
